>>> hdl/bfp_pkg.sv
// Shared types and constants of the box filter image pyramid.
package bfp_pkg;

  localparam int PIX_W        = 8;
  localparam int LVL_W        = 4;
  localparam int OX_W         = 12;
  localparam int OY_W         = 16;
  localparam int POS_W        = 16;
  localparam int SUM_W        = 30;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 17;
  localparam int LEVELS_REG_W = 4;
  localparam int QUEUE_DEPTH  = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_NUM_LEVELS   = 2'd2
  } reg_index_t;

  // One classified pixel on its way from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } item_t;

  // Fill status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hdl/bfp_front.sv
// Front end: configuration registers, raster position counters and item push.
module bfp_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_LEVELS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bfp_pkg::PIX_W-1:0]        pixel,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  bfp_pkg::q_status_t               q_status,
  output logic                             push,
  output bfp_pkg::item_t                   push_item,
  output logic [bfp_pkg::LVL_W:0]          levels
);
  import bfp_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EWW = CW + 1;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [LEVELS_REG_W-1:0] num_levels;
  logic [CW-1:0]           column_count;
  logic [POS_W-1:0]        row_count;

  logic [EWW-1:0]          eff_width;
  logic [HEIGHT_REG_W-1:0] eff_height;
  logic                    col_last;
  logic                    row_last;
  logic                    accept;
  logic                    cfg_wr;
  logic                    cfg_hit;

  // Clamp the registers to their usable ranges.
  always_comb begin
    if (image_width == '0) begin
      eff_width = EWW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_width = EWW'(MAX_WIDTH);
    end else begin
      eff_width = EWW'(image_width);
    end
    if (image_height == '0) begin
      eff_height = HEIGHT_REG_W'(1);
    end else if (32'(image_height) > 32'd65536) begin
      eff_height = HEIGHT_REG_W'(65536);
    end else begin
      eff_height = image_height;
    end
    if (num_levels == '0) begin
      levels = (LVL_W+1)'(1);
    end else if (32'(num_levels) > 32'(MAX_LEVELS)) begin
      levels = (LVL_W+1)'(MAX_LEVELS);
    end else begin
      levels = (LVL_W+1)'(num_levels);
    end
  end

  // Position of the current pixel against the row and image ends.
  assign col_last = (EWW'(column_count) + EWW'(1)) >= eff_width;
  assign row_last = ({1'b0, row_count} + HEIGHT_REG_W'(1)) >= eff_height;

  // Item handshake: the front end only waits on queue space.
  assign in_stall        = q_status.full;
  assign accept          = in_valid && !q_status.full;
  assign push            = accept;
  assign push_item.pixel = pixel;
  assign push_item.x     = POS_W'(column_count);
  assign push_item.y     = row_count;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && ((cfg_index == REG_IMAGE_WIDTH) ||
                                (cfg_index == REG_IMAGE_HEIGHT) ||
                                (cfg_index == REG_NUM_LEVELS));

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(4096);
      image_height <= HEIGHT_REG_W'(4096);
      num_levels   <= LEVELS_REG_W'(8);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        REG_NUM_LEVELS:   num_levels   <= cfg_data[LEVELS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster counters; a register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + POS_W'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

endmodule

>>> hdl/bfp_queue.sv
// Short queue of items between the front end and the back end.
module bfp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bfp_pkg::item_t     push_item,
  input  logic               pop,
  output bfp_pkg::item_t     pop_item,
  output bfp_pkg::q_status_t status
);
  import bfp_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);

  item_t          entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign status.full  = count == (QAW+1)'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign pop_item     = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  // Neither side may overrun or underrun the queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full) else $error("item pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("item popped from an empty queue");

endmodule

>>> hdl/bfp_back.sv
// Back end: walks the pyramid levels of one item, one result per cycle while out_stall is low.
module bfp_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_LEVELS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [bfp_pkg::LVL_W:0]   levels,
  input  bfp_pkg::q_status_t        q_status,
  output logic                      pop,
  input  bfp_pkg::item_t            pop_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bfp_pkg::LVL_W-1:0] level,
  output logic [bfp_pkg::OX_W-1:0]  out_x,
  output logic [bfp_pkg::OY_W-1:0]  out_y,
  output logic [bfp_pkg::PIX_W-1:0] value,
  output logic                      last
);
  import bfp_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam logic [CW:0] MW = (CW+1)'(MAX_WIDTH);

  // Item in work.
  logic             busy;
  logic [LVL_W-1:0] lvl;
  logic [CW-1:0]    xpos;
  logic [POS_W-1:0] ypos;
  logic [PIX_W-1:0] pix;
  logic [SUM_W-1:0] cur;
  logic [SUM_W-1:0] ps_cur;
  logic [SUM_W-1:0] rd;

  // Stores.
  logic [SUM_W-1:0] pair_sums [MAX_LEVELS];
  logic [SUM_W-1:0] row_store [MAX_WIDTH];

  // Deferred row store write.
  logic             wr_valid;
  logic [CW-1:0]    wr_addr;
  logic [SUM_W-1:0] wr_a;
  logic [SUM_W-1:0] wr_b;

  // Output register.
  logic             ovalid;
  logic [LVL_W-1:0] olevel;
  logic [OX_W-1:0]  ox;
  logic [OY_W-1:0]  oy;
  logic [SUM_W-1:0] ototal;
  logic             olast;

  logic             out_ok;
  logic             step;
  logic             load;
  logic [LVL_W:0]   lvl_n;
  logic [CW-1:0]    x_sh;
  logic [POS_W-1:0] y_sh;
  logic [SUM_W-1:0] tot;
  logic             is_last;
  logic             has_next;
  logic [SUM_W-1:0] ps_rd;
  logic [CW-1:0]    col;
  logic [CW:0]      base;
  logic [CW:0]      idx_sum;
  logic [CW-1:0]    rd_addr;
  logic [4:0]       shamt;
  logic [SUM_W:0]   rounded;

  // A level step runs whenever the output register can take its result.
  assign out_ok = !ovalid || !out_stall;
  assign step   = busy && out_ok;

  // Sum of the current level and whether the walk ends here.
  always_comb begin
    lvl_n    = {1'b0, lvl} + (LVL_W+1)'(1);
    x_sh     = xpos >> lvl;
    y_sh     = ypos >> lvl;
    tot      = (lvl == '0) ? SUM_W'(pix) : rd + ps_cur + cur;
    has_next = lvl_n < levels;
    is_last  = !has_next || !x_sh[0] || !y_sh[0];
    ps_rd    = (lvl_n < (LVL_W+1)'(MAX_LEVELS)) ? pair_sums[PIW'(lvl_n)] : '0;
  end

  // Row store address of the next level: its region plus the pair column.
  always_comb begin
    col     = xpos >> lvl_n;
    base    = MW - (MW >> (lvl_n - (LVL_W+1)'(1)));
    idx_sum = base + (CW+1)'(col);
    if (idx_sum >= MW) begin
      rd_addr = CW'(idx_sum - MW);
    end else begin
      rd_addr = CW'(idx_sum);
    end
  end

  // Take a new item when idle or when the current one finishes.
  assign load = (!busy || (step && is_last)) && !q_status.empty;
  assign pop  = load;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      ovalid   <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      if (out_ok) ovalid <= step;
      if (load) begin
        busy <= 1'b1;
      end else if (step && is_last) begin
        busy <= 1'b0;
      end
      wr_valid <= step && is_last && has_next && x_sh[0];
    end
  end

  // Item registers and level walk.
  always_ff @(posedge clk) begin
    if (load) begin
      lvl  <= '0;
      pix  <= pop_item.pixel;
      xpos <= pop_item.x[CW-1:0];
      ypos <= pop_item.y;
    end else if (step && !is_last) begin
      lvl    <= lvl_n[LVL_W-1:0];
      cur    <= tot;
      ps_cur <= ps_rd;
    end
  end

  // Result capture.
  always_ff @(posedge clk) begin
    if (step) begin
      olevel <= lvl;
      ox     <= OX_W'(x_sh);
      oy     <= y_sh;
      ototal <= tot;
      olast  <= is_last;
    end
  end

  // A walk that stops at a left half keeps the sum for its partner.
  always_ff @(posedge clk) begin
    if (step && is_last && has_next && !x_sh[0]) begin
      pair_sums[PIW'(lvl_n)] <= tot;
    end
  end

  // A finished pair on an even block row is stored in the following cycle.
  always_ff @(posedge clk) begin
    wr_addr <= rd_addr;
    wr_a    <= ps_rd;
    wr_b    <= tot;
  end

  // Row store: one deferred write per cycle and one registered read per level step.
  always_ff @(posedge clk) begin
    if (wr_valid) row_store[wr_addr] <= wr_a + wr_b;
    if (step) rd <= row_store[rd_addr];
  end

  // Rounded mean of the captured block sum.
  always_comb begin
    shamt   = {olevel, 1'b0};
    rounded = {1'b0, ototal} + ((SUM_W+1)'(1) << (shamt - 5'd1));
    if (olevel == '0) begin
      value = ototal[PIX_W-1:0];
    end else begin
      value = PIX_W'(rounded >> shamt);
    end
  end

  assign out_valid = ovalid;
  assign level     = olevel;
  assign out_x     = ox;
  assign out_y     = oy;
  assign last      = olast;

  // Results stay within the configured levels and follow in level order.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> ({1'b0, olevel} < levels)) else $error("result level out of range");
  a_level_order: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !out_stall && !olast) |=>
      (ovalid && (olevel == $past(olevel) + LVL_W'(1))))
    else $error("result levels of one item not consecutive");

endmodule

>>> hdl/box_filter_image_pyramid.sv
// Top level of the streaming 2x2 box-mean image pyramid.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall     pixel
//   cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//   out      source     out_valid / out_stall   level, out_x, out_y, value, last
//
// The back end emits one result per cycle while out_stall is low; an item
// has 1 to num_levels results, about 1.33 on average. That rate is set by
// the single result register and the level walk of the back end; a
// four-entry queue lets the front end keep taking items meanwhile.
// The first result of an item passes the queue, the item registers and the result register.
// Reset is synchronous; it clears counters and handshake state and loads configuration defaults.
// The sum stores are not cleared and need no clearing pass.
// out_stall holds the back end; in_stall rises only when the queue is full.
module box_filter_image_pyramid #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_LEVELS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bfp_pkg::PIX_W-1:0]      pixel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bfp_pkg::LVL_W-1:0]      level,
  output logic [bfp_pkg::OX_W-1:0]       out_x,
  output logic [bfp_pkg::OY_W-1:0]       out_y,
  output logic [bfp_pkg::PIX_W-1:0]      value,
  output logic                           last
);
  import bfp_pkg::*;

  q_status_t        q_status;
  logic             push;
  item_t            push_item;
  logic             pop;
  item_t            pop_item;
  logic [LVL_W:0]   levels;

  // Position tracking and configuration.
  bfp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item),
    .levels    (levels)
  );

  // Decoupling queue.
  bfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // Level sums and results.
  bfp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .levels    (levels),
    .q_status  (q_status),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level     (level),
    .out_x     (out_x),
    .out_y     (out_y),
    .value     (value),
    .last      (last)
  );

endmodule
